// ===== sv/fprf_pkg.sv =====
package fprf_pkg;

    localparam int NUM_REGS   = 32;
    localparam int ENTRY_W    = $clog2(NUM_REGS);
    localparam int DATA_W     = 64;
    localparam int HALF_W     = 32;
    localparam int REQ_W      = 3;
    localparam int STEP_W     = ENTRY_W - 1;

    // Power-on status word; its FR bit sets the mode after reset.
    localparam logic [31:0] POWERON_STATUS  = 32'h3400_0000;
    localparam int          STATUS_FR_SHIFT = 26;

    localparam logic [REQ_W-1:0] REQ_WRITE_SINGLE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ_SINGLE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE_DOUBLE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ_DOUBLE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SET_MODE     = 3'd4;

    typedef logic [DATA_W-1:0]  t_word;
    typedef logic [ENTRY_W-1:0] t_entry;

endpackage

// ===== sv/fprf_if.sv =====
interface fprf_req_if;
    logic                           valid;
    logic                           ready;
    logic [fprf_pkg::REQ_W-1:0]     req_type;
    logic [fprf_pkg::ENTRY_W-1:0]   reg_index;
    logic [fprf_pkg::DATA_W-1:0]    write_data;
    logic                           new_fr;

    modport source (output valid, req_type, reg_index, write_data, new_fr, input ready);
    modport sink   (input valid, req_type, reg_index, write_data, new_fr, output ready);
endinterface

interface fprf_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [fprf_pkg::DATA_W-1:0]    read_data;
    logic                           fr_mode;

    modport source (output valid, read_data, fr_mode, input ready);
    modport sink   (input valid, read_data, fr_mode, output ready);
endinterface

// ===== sv/fprf_ram.sv =====
module fprf_ram #(
    parameter int WIDTH = fprf_pkg::DATA_W,
    parameter int DEPTH = fprf_pkg::NUM_REGS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fpu_register_file_fr_mode_unit.sv =====
// Floating-point register file, 32 entries of 64 bits, with an FR mode bit.
// i_req carries one request item: single or double read or write by register
// number, or a mode change. o_rsp returns one item per request: the read value
// (single reads zero-extended, zero otherwise) and the FR mode after it.
// Both channels use valid/ready; an item moves when both are high.
// A new request is taken only once the last one is through: the accepting
// cycle issues the memory read, and the execute state then merges, writes
// back and loads the output register as soon as that register is free.
// A mode change that flips FR repacks the file through a second memory bank,
// two entries at a time, before its result is registered.
// Reset sets FR to one and marks every entry invalid; invalid entries read as
// zero, so the file reads as cleared right after reset without a clearing pass.
// When the receiver stalls, the result waits in the output register; the next
// request can still be accepted and is held before write back until the output
// register is free, so no result is lost or reordered.
module fpu_register_file_fr_mode_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fprf_req_if.sink       i_req,
    fprf_rsp_if.source     o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_PACK = 2'd2;

    localparam int STEP_W = fprf_pkg::STEP_W;
    localparam int HW     = fprf_pkg::HALF_W;
    localparam int DW     = fprf_pkg::DATA_W;
    localparam int NR     = fprf_pkg::NUM_REGS;

    logic [1:0]                  r_state;
    logic                        r_fr;
    logic                        r_bank;
    logic [NR-1:0]               r_valid;
    logic                        r_rd_valid;
    logic [fprf_pkg::REQ_W-1:0]  r_req;
    fprf_pkg::t_entry            r_entry;
    logic                        r_hi;
    fprf_pkg::t_word             r_data;
    logic                        r_nfr;
    logic [STEP_W-1:0]           r_step;
    logic [1:0]                  r_ph;
    fprf_pkg::t_word             r_a;
    fprf_pkg::t_word             r_b;
    logic                        r_out_valid;
    fprf_pkg::t_word             r_out_data;
    logic                        r_out_fr;

    logic                        accept;
    logic                        out_free;
    logic                        flip;
    logic                        finish;
    logic                        pack_done;
    fprf_pkg::t_entry            in_entry;
    fprf_pkg::t_entry            raddr;
    fprf_pkg::t_entry            addr_a;
    fprf_pkg::t_entry            addr_b;
    fprf_pkg::t_entry            waddr;
    fprf_pkg::t_word             wdata;
    logic                        we_cur;
    logic                        we_alt;
    fprf_pkg::t_word             rd0;
    fprf_pkg::t_word             rd1;
    fprf_pkg::t_word             cur;
    fprf_pkg::t_word             n_out_data;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign flip     = (r_req == fprf_pkg::REQ_SET_MODE) && (r_nfr != r_fr);
    assign finish   = (r_state == S_EXEC) && !flip && out_free;
    assign pack_done = (r_state == S_PACK) && (r_ph == 2'd3) && (&r_step);

    assign i_req.ready = (r_state == S_IDLE);

    // FR=0 maps register pairs onto one entry, odd numbers in the high half.
    assign in_entry = r_fr ? i_req.reg_index : {1'b0, i_req.reg_index[fprf_pkg::ENTRY_W-1:1]};

    // Repack source pair read for the current step.
    assign addr_a = r_nfr ? {1'b0, r_step} : {r_step, 1'b0};
    assign addr_b = r_nfr ? {1'b1, r_step} : {r_step, 1'b1};

    assign cur = (r_bank ? rd1 : rd0) & {DW{r_rd_valid}};

    always_comb begin
        case (r_state)
            S_IDLE:  raddr = in_entry;
            S_EXEC:  raddr = r_entry;
            S_PACK:  raddr = (r_ph == 2'd0) ? addr_a : addr_b;
            default: raddr = r_entry;
        endcase
    end

    always_comb begin
        we_cur     = 1'b0;
        we_alt     = 1'b0;
        waddr      = r_entry;
        wdata      = r_data;
        n_out_data = '0;
        if (r_state == S_EXEC) begin
            case (r_req)
                fprf_pkg::REQ_WRITE_SINGLE: begin
                    we_cur = finish;
                    wdata  = r_hi ? {r_data[HW-1:0], cur[HW-1:0]}
                                  : {cur[DW-1:HW], r_data[HW-1:0]};
                end
                fprf_pkg::REQ_READ_SINGLE: begin
                    n_out_data = {{HW{1'b0}}, (r_hi ? cur[DW-1:HW] : cur[HW-1:0])};
                end
                fprf_pkg::REQ_WRITE_DOUBLE: begin
                    we_cur = finish;
                end
                fprf_pkg::REQ_READ_DOUBLE: begin
                    n_out_data = cur;
                end
                default: begin
                end
            endcase
        end else if (r_state == S_PACK) begin
            if (r_ph == 2'd2) begin
                we_alt = 1'b1;
                waddr  = r_nfr ? {r_step, 1'b0} : {1'b0, r_step};
                wdata  = {cur[HW-1:0], r_a[HW-1:0]};
            end else if (r_ph == 2'd3) begin
                we_alt = 1'b1;
                waddr  = r_nfr ? {r_step, 1'b1} : {1'b1, r_step};
                wdata  = {r_b[DW-1:HW], r_a[DW-1:HW]};
            end
        end
    end

    fprf_ram #(
        .WIDTH (DW),
        .DEPTH (NR)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    ((we_cur && !r_bank) || (we_alt && r_bank)),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd0)
    );

    fprf_ram #(
        .WIDTH (DW),
        .DEPTH (NR)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    ((we_cur && r_bank) || (we_alt && !r_bank)),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fr        <= fprf_pkg::POWERON_STATUS[fprf_pkg::STATUS_FR_SHIFT];
            r_bank      <= 1'b0;
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
            r_step      <= '0;
            r_ph        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[raddr];
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (flip) begin
                        r_state <= S_PACK;
                        r_step  <= '0;
                        r_ph    <= '0;
                    end else if (out_free) begin
                        r_state <= S_IDLE;
                        if (we_cur) begin
                            r_valid[r_entry] <= 1'b1;
                        end
                    end
                end
                S_PACK: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == 2'd3) begin
                        r_step <= r_step + 1'b1;
                    end
                    if (pack_done) begin
                        r_state <= S_EXEC;
                        r_bank  <= !r_bank;
                        r_valid <= '1;
                        r_fr    <= r_nfr;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_req.req_type;
            r_entry <= in_entry;
            r_hi    <= !r_fr && i_req.reg_index[0];
            r_data  <= i_req.write_data;
            r_nfr   <= i_req.new_fr;
        end
        if (r_state == S_PACK && r_ph == 2'd1) begin
            r_a <= cur;
        end
        if (r_state == S_PACK && r_ph == 2'd2) begin
            r_b <= cur;
        end
        if (finish) begin
            r_out_data <= n_out_data;
            r_out_fr   <= r_fr;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;
    assign o_rsp.fr_mode   = r_out_fr;

endmodule
